// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge out of reset
`define AM_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define AM_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define AM_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/mmh_pkg.sv
// Shared types and constants for the MurmurHash3 x86_32 stream hasher
`timescale 1ns / 1ps
package mmh_pkg;

	localparam int unsigned COUNT_W = 3;

	localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
	localparam logic [31:0] MIX_C2  = 32'h1b873593;
	localparam logic [31:0] MIX_ADD = 32'he6546b64;
	localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
	localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;
	localparam logic [31:0] SEED_RESET = 32'd23;

	localparam logic [COUNT_W-1:0] BYTES_NONE = 3'd0;
	localparam logic [COUNT_W-1:0] BYTES_ONE  = 3'd1;
	localparam logic [COUNT_W-1:0] BYTES_TWO  = 3'd2;
	localparam logic [COUNT_W-1:0] BYTES_THREE = 3'd3;
	localparam logic [COUNT_W-1:0] BYTES_FULL = 3'd4;

	// scrambled word on its way from front to back
	typedef struct packed {
		logic [31:0]        k;
		logic [COUNT_W-1:0] count;
		logic               last;
	} mid_item_t;

endpackage

// File: rtl/core/mmh_fifo.sv
// Small first-word-fall-through queue built from registers
`timescale 1ns / 1ps
module mmh_fifo #(
	parameter int unsigned WIDTH = 36,
	parameter int unsigned DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rd_data,
	output logic [$clog2(DEPTH+1)-1:0] level,
	output logic                       empty
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned LW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [LW-1:0]    level_q;
	logic             do_rd;

	assign do_rd   = rd_en && (level_q != '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign level   = level_q;
	assign empty   = (level_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !do_rd) begin
				level_q <= level_q + 1'b1;
			end else if (!wr_en && do_rd) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: rtl/core/mmh_front.sv
// Front end: takes words, masks and classifies them, scrambles the key word
`timescale 1ns / 1ps
module mmh_front #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic [31:0]                       data_word,
	input  logic [mmh_pkg::COUNT_W-1:0]       byte_count,
	input  logic                              last,
	input  logic [$clog2(DEPTH+1)-1:0]        level,
	output logic                              full,
	output logic                              out_valid,
	output mmh_pkg::mid_item_t                out_item
);
	localparam int unsigned LW  = $clog2(DEPTH+1);
	localparam int unsigned LW1 = LW + 1;

	logic                          accept;
	logic [mmh_pkg::COUNT_W-1:0]   cnt_sat;
	logic [31:0]                   masked;
	logic [LW1-1:0]                in_flight;

	logic                          v_s1;
	logic [31:0]                   w_s1;
	logic [mmh_pkg::COUNT_W-1:0]   cnt_s1;
	logic                          last_s1;
	logic                          v_s2;
	logic [31:0]                   k_s2;
	logic [mmh_pkg::COUNT_W-1:0]   cnt_s2;
	logic                          last_s2;
	logic [31:0]                   k_rot;

	// queue level plus requests still in the two front stages
	assign in_flight = LW1'(level) + LW1'(v_s1) + LW1'(v_s2);
	assign full      = (in_flight >= LW1'(DEPTH));
	assign accept    = push && !full;

	assign cnt_sat = (byte_count > mmh_pkg::BYTES_FULL) ? mmh_pkg::BYTES_FULL : byte_count;

	always_comb begin
		unique case (cnt_sat)
			mmh_pkg::BYTES_NONE:  masked = 32'h0;
			mmh_pkg::BYTES_ONE:   masked = {24'h0, data_word[7:0]};
			mmh_pkg::BYTES_TWO:   masked = {16'h0, data_word[15:0]};
			mmh_pkg::BYTES_THREE: masked = {8'h0, data_word[23:0]};
			default:              masked = data_word;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			// an empty word that does not close the message changes nothing
			v_s1 <= accept && !((cnt_sat == mmh_pkg::BYTES_NONE) && !last);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		w_s1    <= masked;
		cnt_s1  <= cnt_sat;
		last_s1 <= last;
		k_s2    <= 32'(w_s1 * mmh_pkg::MIX_C1);
		cnt_s2  <= cnt_s1;
		last_s2 <= last_s1;
	end

	assign k_rot          = {k_s2[16:0], k_s2[31:17]};
	assign out_valid      = v_s2;
	assign out_item.k     = 32'(k_rot * mmh_pkg::MIX_C2);
	assign out_item.count = cnt_s2;
	assign out_item.last  = last_s2;

endmodule

// File: rtl/core/mmh_back.sv
// Back end: running hash, byte total, seed register and final mix pipeline
`timescale 1ns / 1ps
module mmh_back #(
	parameter int unsigned OUT_DEPTH = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	input  mmh_pkg::mid_item_t                item,
	output logic                              item_pop,
	input  logic [$clog2(OUT_DEPTH+1)-1:0]    out_level,
	input  logic                              seed_valid,
	output logic                              seed_ready,
	input  logic [31:0]                       seed,
	output logic                              result_valid,
	output logic [31:0]                       result_hash
);
	localparam int unsigned LW  = $clog2(OUT_DEPTH+1);
	localparam int unsigned LW1 = LW + 1;

	logic [31:0]    seed_q;
	logic [31:0]    hash_q;
	logic [31:0]    total_q;
	logic [LW1-1:0] in_flight;
	logic           take;
	logic [31:0]    h_x;
	logic [31:0]    h_rot;
	logic [31:0]    h_body;
	logic [31:0]    h_new;
	logic [31:0]    tot_new;
	logic [31:0]    fin;
	logic [31:0]    y_s2;

	logic           v_s1;
	logic           v_s2;
	logic           v_s3;
	logic [31:0]    x_s1;
	logic [31:0]    x_s2;
	logic [31:0]    x_s3;

	// results in the final mix plus those already queued
	assign in_flight = LW1'(out_level) + LW1'(v_s1) + LW1'(v_s2) + LW1'(v_s3);
	assign take      = item_valid && (in_flight < LW1'(OUT_DEPTH));
	assign item_pop  = take;
	assign seed_ready = 1'b1;

	assign h_x     = hash_q ^ item.k;
	assign h_rot   = {h_x[18:0], h_x[31:19]};
	assign h_body  = (h_rot << 2) + h_rot + mmh_pkg::MIX_ADD;
	assign h_new   = (item.count == mmh_pkg::BYTES_FULL) ? h_body : h_x;
	assign tot_new = total_q + 32'(item.count);
	assign fin     = h_new ^ tot_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= mmh_pkg::SEED_RESET;
			hash_q  <= mmh_pkg::SEED_RESET;
			total_q <= 32'h0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			v_s1 <= take && item.last;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (take) begin
				if (item.last) begin
					hash_q  <= seed_q;
					total_q <= 32'h0;
				end else begin
					hash_q  <= h_new;
					total_q <= tot_new;
				end
			end
			// new seed reaches the running hash only while the byte total is zero
			if (seed_valid) begin
				seed_q <= seed;
				if (total_q == 32'h0) begin
					hash_q <= seed;
				end
			end
		end
	end

	assign y_s2 = x_s2 ^ (x_s2 >> 13);

	always_ff @(posedge clk) begin
		x_s1 <= fin ^ (fin >> 16);
		x_s2 <= 32'(x_s1 * mmh_pkg::FIN_M1);
		x_s3 <= 32'(y_s2 * mmh_pkg::FIN_M2);
	end

	assign result_valid = v_s3;
	assign result_hash  = x_s3 ^ (x_s3 >> 16);

endmodule

// File: rtl/core/murmur3_32_hash_stream.sv
// Top level of the MurmurHash3 x86_32 stream hasher
// A last word accepted with push shows its hash (empty low) once it has passed two scramble
// stages, the mid queue, three final-mix stages and the out queue.
// Throughput: one word per cycle while full is low; a run of last words is limited by the free
// room in the out queue, and a held-off pop stalls the input through full.
// Reset (arst_n low): queues empty, seed and running hash 23, byte total zero.
`timescale 1ns / 1ps
module murmur3_32_hash_stream #(
	parameter int unsigned QUEUE_DEPTH = 4,
	parameter int unsigned OUT_DEPTH   = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [31:0]                 data_word,
	input  logic [mmh_pkg::COUNT_W-1:0] byte_count,
	input  logic                        last,
	output logic                        empty,
	input  logic                        pop,
	output logic [31:0]                 hash,
	input  logic                        seed_valid,
	output logic                        seed_ready,
	input  logic [31:0]                 seed
);
	localparam int unsigned MID_W = $bits(mmh_pkg::mid_item_t);

	mmh_pkg::mid_item_t                 front_item;
	mmh_pkg::mid_item_t                 mid_item;
	logic                               front_valid;
	logic                               mid_empty;
	logic                               mid_pop;
	logic [$clog2(QUEUE_DEPTH+1)-1:0]   mid_level;
	logic [$clog2(OUT_DEPTH+1)-1:0]     out_level;
	logic                               res_valid;
	logic [31:0]                        res_hash;

	mmh_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last       (last),
		.level      (mid_level),
		.full       (full),
		.out_valid  (front_valid),
		.out_item   (front_item)
	);

	mmh_fifo #(.WIDTH(MID_W), .DEPTH(QUEUE_DEPTH)) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_valid),
		.wr_data (front_item),
		.rd_en   (mid_pop),
		.rd_data (mid_item),
		.level   (mid_level),
		.empty   (mid_empty)
	);

	mmh_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (!mid_empty),
		.item         (mid_item),
		.item_pop     (mid_pop),
		.out_level    (out_level),
		.seed_valid   (seed_valid),
		.seed_ready   (seed_ready),
		.seed         (seed),
		.result_valid (res_valid),
		.result_hash  (res_hash)
	);

	mmh_fifo #(.WIDTH(32), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res_hash),
		.rd_en   (pop),
		.rd_data (hash),
		.level   (out_level),
		.empty   (empty)
	);

endmodule

// File: rtl/core/mmh_checker.sv
// Port-level checker for the stream hasher, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mmh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        last,
	input logic        empty,
	input logic        pop,
	input logic [31:0] hash,
	input logic        seed_ready
);
	logic [15:0] lasts_q;
	logic [15:0] pops_q;

	// messages closed versus hashes taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lasts_q <= 16'h0;
			pops_q  <= 16'h0;
		end else begin
			if (push && !full && last) begin
				lasts_q <= lasts_q + 1'b1;
			end
			if (pop && !empty) begin
				pops_q <= pops_q + 1'b1;
			end
		end
	end

	`AM_NEXT(a_hash_holds, !empty && !pop, $stable(hash) && !empty, "waiting hash changed")
	`AM_IMPLIES(a_no_stray_hash, lasts_q == pops_q, empty, "hash shown with no message closed")
	`AM_ALWAYS(a_seed_ready, seed_ready, "seed write not taken")

endmodule

bind murmur3_32_hash_stream mmh_checker u_mmh_checker (.*);
